// ----- rtl/core/bia_pkg.sv -----
package bia_pkg;

    // Fixed field widths of the request, the result and the registers.
    localparam int SLOT_W        = 10;
    localparam int HW_W          = 11;
    localparam int BYTES_W       = 29;
    localparam int BLOCK_BYTES_W = 19;
    localparam int SPACE_W       = 48;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 48;

    // Bitmap word geometry.
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RESET = 19'd262144;
    localparam logic [SPACE_W-1:0]       SPACE_LIMIT_RESET = {SPACE_W{1'b1}};
    localparam logic [BYTES_W-1:0]       BYTES_MAX         = {BYTES_W{1'b1}};

    // Operation codes.
    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_RELEASE  = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_SPACE    = 2'd1;
    localparam logic [1:0] ST_NOT_IN_USE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_LIMIT = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  granted_slot;
        logic [HW_W-1:0]    high_water;
        logic               truncated;
        logic [BYTES_W-1:0] bytes_on_disk;
    } result_t;

    // Position of the lowest set bit of a word; zero when the word is empty.
    function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // Position of the highest set bit of a word; zero when the word is empty.
    function automatic logic [BIT_W-1:0] highest_one(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- rtl/core/bia_map_ram.sv -----
module bia_map_ram
    import bia_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/bia_mult.sv -----
module bia_mult #(
    parameter int A_W = 12,
    parameter int B_W = 19
) (
    input  logic               clk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] product_reg
);

    // Shared multiplier for the space check and the byte count.
    always_ff @(posedge clk)
    begin
        product_reg <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
    end

endmodule

// ----- rtl/core/block_index_allocator.sv -----
// Slot index allocator. A command is taken when start is high and busy is low; its result
// appears on result for exactly one cycle with done high and must be captured then, since
// the receiver cannot stall it. The result comes in the first cycle after busy falls, and
// the next command can be taken at the end of that same cycle. An allocate scans the
// in-use bitmap one 32-bit word per cycle through a single RAM read port for a free slot
// below the mark; on an empty map, or when every word below the mark is full, the mark is
// raised if a slot remains and the space limit holds, else the status is no space.
// A release of a slot below the slot count reads its word; a used slot has its bit cleared,
// then a scan runs downward from the mark for the highest used slot. A slot not in use, or
// one at or beyond the slot count, is reported not in use. One shared multiplier forms both
// the space check and bytes_on_disk. After reset the bitmap RAM is cleared one word per
// cycle with busy held high; configuration writes are taken throughout.
module block_index_allocator
    import bia_pkg::*;
#(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  request_t              request,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WORDS   = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MARK_W  = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int EXT_W   = WA_W + BIT_W + 1;
    localparam int MUL_A_W = MARK_W + 1;
    localparam int PROD_W  = MUL_A_W + BLOCK_BYTES_W;
    localparam int CMP_W   = (PROD_W > SPACE_W) ? PROD_W : SPACE_W;
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_AL_SCAN  = 11'b000_0000_0100,
        S_AL_GROW  = 11'b000_0000_1000,
        S_AL_LIMIT = 11'b000_0001_0000,
        S_AL_SET   = 11'b000_0010_0000,
        S_RL_CHK   = 11'b000_0100_0000,
        S_RL_SCAN  = 11'b000_1000_0000,
        S_MUL      = 11'b001_0000_0000,
        S_FINISH   = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [MARK_W-1:0]        mark_reg, mark_next;
    logic [WA_W-1:0]          ptr_reg, ptr_next;
    logic                     pend_reg, pend_next;
    logic [WA_W-1:0]          pend_addr_reg;
    logic [WA_W-1:0]          last_word_reg, last_word_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [1:0]               status_reg, status_next;
    logic [IDX_W-1:0]         granted_reg, granted_next;
    logic                     trunc_reg, trunc_next;
    logic                     done_reg, done_next;
    result_t                  result_reg, result_next;
    logic [BLOCK_BYTES_W-1:0] block_bytes_reg;
    logic [SPACE_W-1:0]       space_limit_reg;

    logic                     ram_we;
    logic [WA_W-1:0]          ram_waddr;
    logic [WORD_BITS-1:0]     ram_wdata;
    logic [WA_W-1:0]          ram_raddr;
    logic [WORD_BITS-1:0]     ram_rdata;

    logic [MUL_A_W-1:0]       mul_a;
    logic [PROD_W-1:0]        product;
    logic [CMP_W-1:0]         prod_cmp;

    logic [EXT_W-1:0]         mark_x;
    logic [EXT_W-1:0]         mark_round;
    logic [WA_W:0]            mark_word;
    logic [BIT_W-1:0]         mark_bit;
    logic [WA_W:0]            words_used;
    logic [WA_W:0]            pend_x;
    logic [WORD_BITS-1:0]     below_mark;
    logic [WORD_BITS-1:0]     free_bits;
    logic [BIT_W-1:0]         free_pos;
    logic [BIT_W-1:0]         used_pos;
    logic [EXT_W-1:0]         top_x;
    logic [31:0]              slot_wide;
    logic [31:0]              mark_wide;
    logic [31:0]              granted_wide;
    logic [31:0]              hw_wide;

    bia_map_ram #(
        .DEPTH  (WORDS),
        .ADDR_W (WA_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bia_mult #(
        .A_W (MUL_A_W),
        .B_W (BLOCK_BYTES_W)
    ) u_mult (
        .clk         (clk),
        .a           (mul_a),
        .b           (block_bytes_reg),
        .product_reg (product)
    );

    // Mark geometry and scan helpers.
    assign mark_x     = EXT_W'(mark_reg);
    assign mark_round = mark_x + EXT_W'(WORD_BITS - 1);
    assign mark_word  = mark_x[EXT_W-1:BIT_W];
    assign mark_bit   = mark_x[BIT_W-1:0];
    assign words_used = mark_round[EXT_W-1:BIT_W];
    assign pend_x     = {1'b0, pend_addr_reg};
    assign free_bits  = ~ram_rdata & below_mark;
    assign free_pos   = lowest_one(free_bits);
    assign used_pos   = highest_one(ram_rdata);
    assign top_x      = (ram_rdata == '0) ? '0
                      : EXT_W'({pend_addr_reg, used_pos}) + EXT_W'(1);
    assign slot_wide  = 32'(slot_reg);
    assign mark_wide  = 32'(mark_reg);
    assign prod_cmp   = CMP_W'(product);

    always_comb
    begin
        if (pend_x < mark_word)
        begin
            below_mark = '1;
        end
        else if (pend_x == mark_word)
        begin
            below_mark = (WORD_BITS'(1) << mark_bit) - WORD_BITS'(1);
        end
        else
        begin
            below_mark = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= BLOCK_BYTES_RESET;
            space_limit_reg <= SPACE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_BYTES: block_bytes_reg <= cfg_data[BLOCK_BYTES_W-1:0];
                CFG_SPACE_LIMIT: space_limit_reg <= cfg_data[SPACE_W-1:0];
                default:         space_limit_reg <= space_limit_reg;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        mark_next      = mark_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        last_word_next = last_word_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        trunc_next     = trunc_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = '0;
        ram_raddr      = ptr_reg;
        mul_a          = MUL_A_W'(mark_reg);
        granted_wide   = 32'(granted_reg);
        hw_wide        = 32'(mark_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = '0;
                ptr_next  = ptr_reg + WA_W'(1);
                if (ptr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                ram_raddr = WA_W'(32'(request.slot) >> BIT_W);
                if (start)
                begin
                    slot_next      = request.slot;
                    status_next    = ST_OK;
                    granted_next   = '0;
                    trunc_next     = 1'b0;
                    pend_next      = 1'b0;
                    last_word_next = WA_W'(words_used - (WA_W + 1)'(1));
                    if (request.operation == OP_ALLOCATE)
                    begin
                        ptr_next   = '0;
                        state_next = (mark_reg == '0) ? S_AL_GROW : S_AL_SCAN;
                    end
                    else if (32'(request.slot) >= 32'(SLOT_COUNT))
                    begin
                        status_next = ST_NOT_IN_USE;
                        state_next  = S_MUL;
                    end
                    else
                    begin
                        state_next = S_RL_CHK;
                    end
                end
            end

            // Walk the words below the mark, looking for a free bit.
            S_AL_SCAN:
            begin
                ram_raddr = ptr_reg;
                ptr_next  = ptr_reg + WA_W'(1);
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (free_bits != '0)
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = pend_addr_reg;
                        ram_wdata    = ram_rdata | (WORD_BITS'(1) << free_pos);
                        granted_next = IDX_W'({pend_addr_reg, free_pos});
                        state_next   = S_MUL;
                    end
                    else if (pend_addr_reg == last_word_reg)
                    begin
                        state_next = S_AL_GROW;
                    end
                end
            end

            S_AL_GROW:
            begin
                mul_a      = MUL_A_W'(mark_reg) + MUL_A_W'(1);
                state_next = S_AL_LIMIT;
            end

            // Raise the mark only while a slot remains and the space limit holds.
            S_AL_LIMIT:
            begin
                ram_raddr = WA_W'(mark_word);
                if (mark_wide < 32'(SLOT_COUNT) && prod_cmp <= CMP_W'(space_limit_reg))
                begin
                    state_next = S_AL_SET;
                end
                else
                begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_MUL;
                end
            end

            S_AL_SET:
            begin
                ram_we       = 1'b1;
                ram_waddr    = WA_W'(mark_word);
                ram_wdata    = ram_rdata | (WORD_BITS'(1) << mark_bit);
                granted_next = IDX_W'(mark_reg);
                mark_next    = mark_reg + MARK_W'(1);
                state_next   = S_MUL;
            end

            // Check that the released slot is in use and clear its bit.
            S_RL_CHK:
            begin
                if (!ram_rdata[slot_reg[BIT_W-1:0]])
                begin
                    status_next = ST_NOT_IN_USE;
                    state_next  = S_MUL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = WA_W'(slot_wide >> BIT_W);
                    ram_wdata  = ram_rdata & ~(WORD_BITS'(1) << slot_reg[BIT_W-1:0]);
                    ptr_next   = last_word_reg;
                    pend_next  = 1'b0;
                    state_next = S_RL_SCAN;
                end
            end

            // Walk downward for the highest slot still in use.
            S_RL_SCAN:
            begin
                ram_raddr = ptr_reg;
                ptr_next  = ptr_reg - WA_W'(1);
                pend_next = 1'b1;
                if (pend_reg && (ram_rdata != '0 || pend_addr_reg == '0))
                begin
                    mark_next  = MARK_W'(top_x);
                    trunc_next = (MARK_W'(top_x) != mark_reg);
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                mul_a      = MUL_A_W'(mark_reg);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                result_next.status        = status_reg;
                result_next.granted_slot  = granted_wide[SLOT_W-1:0];
                result_next.high_water    = hw_wide[HW_W-1:0];
                result_next.truncated     = trunc_reg;
                result_next.bytes_on_disk = (prod_cmp > CMP_W'(BYTES_MAX)) ? BYTES_MAX
                                          : prod_cmp[BYTES_W-1:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            mark_reg  <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mark_reg  <= mark_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= ptr_reg;
        last_word_reg <= last_word_next;
        slot_reg      <= slot_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        trunc_reg     <= trunc_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The mark never passes the slot count.
    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(mark_reg) <= 32'(SLOT_COUNT))
        else $error("high-water mark beyond slot count");

    // A result strobe follows the finish step and lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // A truncation is only reported by a successful release.
    a_trunc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.truncated |-> result.status == ST_OK)
        else $error("truncation reported with a failing status");

    // The mark does not move while the block waits for a command.
    a_idle_mark: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && !start |=> $stable(mark_reg))
        else $error("high-water mark changed while idle");

endmodule
